// ===== hdl/ppre_pkg.sv =====
package ppre_pkg;

	localparam int unsigned LUMA_DEFAULT = 128;
	localparam int unsigned MAX_HEIGHT   = 4096;
	localparam int unsigned SIZE_W       = 13;
	localparam int unsigned ROW_W        = 12;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_MEDIAN   = 2'd0,
		MODE_AVERAGE  = 2'd1,
		MODE_GRADIENT = 2'd2,
		MODE_LEFT     = 2'd3
	} mode_t;

	// One column of the previous row, and also the left and top-left neighbors.
	typedef struct packed {
		logic signed [8:0] co;
		logic signed [8:0] cg;
		logic [7:0]        y;
	} line_word_t;

	function automatic logic signed [10:0] predict(
		mode_t             mode,
		logic signed [10:0] l,
		logic signed [10:0] t,
		logic signed [10:0] tl
	);
		logic signed [10:0] hi;
		logic signed [10:0] lo;
		logic signed [10:0] grad;
		logic signed [11:0] sum;
		logic signed [10:0] p;
		hi   = (l > t) ? l : t;
		lo   = (l < t) ? l : t;
		grad = l + t - tl;
		sum  = 12'(l) + 12'(t);
		unique case (mode)
			MODE_MEDIAN: begin
				if (tl >= hi)
					p = lo;
				else if (tl <= lo)
					p = hi;
				else
					p = grad;
			end
			MODE_AVERAGE:  p = 11'(sum >>> 1);
			MODE_GRADIENT: p = grad;
			MODE_LEFT:     p = l;
			default:       p = l;
		endcase
		return p;
	endfunction

	// Maps 0, -1, 1, -2, ... to 0, 1, 2, 3, ...
	function automatic logic [11:0] zigzag(logic signed [11:0] v);
		return {v[10:0], 1'b0} ^ {12{v[11]}};
	endfunction

endpackage

// ===== hdl/pixel_predictive_residual_encoder_unit.sv =====
// Converts a raster stream of RGB pixels to YCgCo-R and codes each plane as the zigzag
// mapped residual against a per-pixel predictor (median edge, average, gradient or left).
// One word is accepted every clock cycle unless the output stalls; a result passes the first
// stage and then the output register. While a result waits with m_tready low, the first
// stage takes one more word and then the input stalls. The rate is set by the line store, a
// single MAX_WIDTH x 26-bit memory that is read when a pixel is accepted and written when
// that pixel leaves the first stage; when the same column is read and written in one cycle
// (one-pixel rows) the new value is forwarded. The line store is not cleared after reset, so
// no clearing pass is needed; every entry of a row is written before the next row reads it.
// The user must write configuration through cfg_we only while the block is idle, which the
// block does not check. Sizes of zero count as one, widths above MAX_WIDTH and heights above
// 4096 saturate. m_tlast marks the last pixel of a row, m_tuser the last of a frame.
module pixel_predictive_residual_encoder_unit #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic [1:0]  s_tuser,   // mode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // luma_code [10:0], cg_code [22:11], co_code [34:23], zero
	output logic        m_tlast,   // row_end
	output logic [0:0]  m_tuser,   // frame_end [0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned WCMP_W = (COL_W + 1 > ppre_pkg::SIZE_W) ? COL_W + 1 : ppre_pkg::SIZE_W;
	localparam int unsigned RESET_SIZE = 32;
	localparam int unsigned RESET_W = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;

	// Configuration, held as effective sizes.
	logic [WCMP_W-1:0]          width_q;
	logic [ppre_pkg::SIZE_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WCMP_W'(RESET_W);
			height_q <= ppre_pkg::SIZE_W'(RESET_SIZE);
		end else if (cfg_we) begin
			unique case (ppre_pkg::reg_index_t'(cfg_index))
				ppre_pkg::REG_IMAGE_WIDTH: begin
					if (cfg_data == '0)
						width_q <= WCMP_W'(1);
					else if (WCMP_W'(cfg_data) > WCMP_W'(MAX_WIDTH))
						width_q <= WCMP_W'(MAX_WIDTH);
					else
						width_q <= WCMP_W'(cfg_data);
				end
				ppre_pkg::REG_IMAGE_HEIGHT: begin
					if (cfg_data == '0)
						height_q <= ppre_pkg::SIZE_W'(1);
					else if (cfg_data > ppre_pkg::SIZE_W'(ppre_pkg::MAX_HEIGHT))
						height_q <= ppre_pkg::SIZE_W'(ppre_pkg::MAX_HEIGHT);
					else
						height_q <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// Handshake between input, first stage and output register.
	logic s1_valid_s1;
	logic s1_adv;
	logic accept;

	assign s1_adv   = s1_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;

	// Color conversion and position at the input.
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;
	logic signed [9:0]   co_in;
	logic signed [9:0]   t_in;
	logic signed [9:0]   cg_in;
	logic signed [9:0]   y_in;
	logic [COL_W-1:0]    col_q;
	logic [ppre_pkg::ROW_W-1:0] row_q;
	logic                last_col;
	logic                last_row;

	assign red   = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign blue  = s_tdata[23:16];

	always_comb begin
		co_in = $signed({2'b00, red}) - $signed({2'b00, blue});
		t_in  = $signed({2'b00, blue}) + (co_in >>> 1);
		cg_in = $signed({2'b00, green}) - t_in;
		y_in  = t_in + (cg_in >>> 1);
	end

	assign last_col = (WCMP_W'(col_q) + WCMP_W'(1)) >= width_q;
	assign last_row = (ppre_pkg::SIZE_W'(row_q) + ppre_pkg::SIZE_W'(1)) >= height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// First stage registers.
	ppre_pkg::line_word_t cur_s1;
	ppre_pkg::mode_t      mode_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 has_left_s1;
	logic                 has_top_s1;
	logic                 last_col_s1;
	logic                 last_frame_s1;
	logic                 byp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			byp_s1      <= 1'b0;
		end else begin
			if (accept || s1_adv)
				s1_valid_s1 <= accept;
			if (accept)
				byp_s1 <= s1_adv && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1.y      <= y_in[7:0];
			cur_s1.cg     <= cg_in[8:0];
			cur_s1.co     <= co_in[8:0];
			mode_s1       <= ppre_pkg::mode_t'(s_tuser);
			col_s1        <= col_q;
			has_left_s1   <= col_q != '0;
			has_top_s1    <= row_q != '0;
			last_col_s1   <= last_col;
			last_frame_s1 <= last_col && last_row;
		end
	end

	// Line store of the previous row.
	ppre_pkg::line_word_t line_mem [MAX_WIDTH];
	ppre_pkg::line_word_t top_raw_s1;

	always_ff @(posedge clk) begin
		if (s1_adv)
			line_mem[col_s1] <= cur_s1;
	end

	always_ff @(posedge clk) begin
		if (accept)
			top_raw_s1 <= line_mem[col_q];
	end

	// Neighbors of the pixel in the first stage.
	ppre_pkg::line_word_t left_q;
	ppre_pkg::line_word_t upleft_q;
	ppre_pkg::line_word_t top_word;

	// The word just written by the previous pixel is also left_q.
	assign top_word = byp_s1 ? left_q : top_raw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_adv) begin
			left_q   <= cur_s1;
			upleft_q <= top_word;
		end
	end

	logic signed [10:0] y_l, y_t, y_tl, cg_l, cg_t, cg_tl, co_l, co_t, co_tl;
	logic signed [10:0] y_p, cg_p, co_p;
	logic signed [11:0] y_res, cg_res, co_res;
	logic [11:0]        y_zz, cg_zz, co_zz;
	logic               has_diag;

	assign has_diag = has_left_s1 && has_top_s1;

	always_comb begin
		y_l   = has_left_s1 ? $signed({3'b000, left_q.y}) : 11'(ppre_pkg::LUMA_DEFAULT);
		y_t   = has_top_s1 ? $signed({3'b000, top_word.y}) : 11'(ppre_pkg::LUMA_DEFAULT);
		y_tl  = has_diag ? $signed({3'b000, upleft_q.y}) : 11'(ppre_pkg::LUMA_DEFAULT);
		cg_l  = has_left_s1 ? 11'(left_q.cg) : '0;
		cg_t  = has_top_s1 ? 11'(top_word.cg) : '0;
		cg_tl = has_diag ? 11'(upleft_q.cg) : '0;
		co_l  = has_left_s1 ? 11'(left_q.co) : '0;
		co_t  = has_top_s1 ? 11'(top_word.co) : '0;
		co_tl = has_diag ? 11'(upleft_q.co) : '0;

		y_p  = ppre_pkg::predict(mode_s1, y_l, y_t, y_tl);
		cg_p = ppre_pkg::predict(mode_s1, cg_l, cg_t, cg_tl);
		co_p = ppre_pkg::predict(mode_s1, co_l, co_t, co_tl);

		y_res  = $signed({4'b0000, cur_s1.y}) - 12'(y_p);
		cg_res = 12'(cur_s1.cg) - 12'(cg_p);
		co_res = 12'(cur_s1.co) - 12'(co_p);

		y_zz  = ppre_pkg::zigzag(y_res);
		cg_zz = ppre_pkg::zigzag(cg_res);
		co_zz = ppre_pkg::zigzag(co_res);
	end

	// Output register.
	logic [10:0] luma_q;
	logic [11:0] cg_q;
	logic [11:0] co_q;
	logic        row_end_q;
	logic        frame_end_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			luma_q      <= y_zz[10:0];
			cg_q        <= cg_zz;
			co_q        <= co_zz;
			row_end_q   <= last_col_s1;
			frame_end_q <= last_frame_s1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {5'b00000, co_q, cg_q, luma_q};
	assign m_tlast    = row_end_q;
	assign m_tuser[0] = frame_end_q;

	// A full first stage behind a stalled output must block the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && s1_valid_s1) |-> !s_tready)
		else $error("input accepted while the first stage is blocked");

	// A stalled first stage keeps its word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_adv) |=> s1_valid_s1)
		else $error("first stage word dropped during a stall");

	// Forwarding only happens when the previous pixel wrote the same column.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && byp_s1) |-> (width_q == WCMP_W'(1) || col_s1 == '0))
		else $error("line store forwarding on a row wider than one pixel");

	// A frame ends only at the end of a row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("frame end without row end");

endmodule
